// ----- rtl/core/rv32x_pkg.sv -----
// ----------------------------------------------------------------------------
// rv32x_pkg
// Shared types, codes and decode constants for the RV32I execute block.
// ----------------------------------------------------------------------------
package rv32x_pkg;

  localparam int MemAddrBitsDefault = 12;

  typedef enum logic [1:0] {
    OP_EXEC = 2'd0,
    OP_PRELOAD = 2'd1,
    OP_SETREG = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_BREAK = 2'd2,
    ST_ECALL = 2'd3
  } status_t;

  localparam logic [6:0] OPC_LOAD = 7'b000_0011;
  localparam logic [6:0] OPC_OPIMM = 7'b001_0011;
  localparam logic [6:0] OPC_AUIPC = 7'b001_0111;
  localparam logic [6:0] OPC_STORE = 7'b010_0011;
  localparam logic [6:0] OPC_OP = 7'b011_0011;
  localparam logic [6:0] OPC_LUI = 7'b011_0111;
  localparam logic [6:0] OPC_BRANCH = 7'b110_0011;
  localparam logic [6:0] OPC_JALR = 7'b110_0111;
  localparam logic [6:0] OPC_JAL = 7'b110_1111;
  localparam logic [6:0] OPC_SYSTEM = 7'b111_0011;
  localparam logic [6:0] F7_ALT = 7'b010_0000;
  localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

endpackage

// ----- rtl/core/rv32x_if.sv -----
// ----------------------------------------------------------------------------
// rv32x_in_if / rv32x_out_if
// Valid/ready channels for instruction transactions and their results.
// ----------------------------------------------------------------------------
interface rv32x_in_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [31:0] instruction;
  logic [11:0] byte_address;
  logic [31:0] write_value;
  logic [4:0] target_register;
  modport source (output valid, operation, instruction, byte_address, write_value,
                  target_register, input ready);
  modport sink (input valid, operation, instruction, byte_address, write_value,
                target_register, output ready);
endinterface

interface rv32x_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [31:0] next_pc;
  logic [4:0] dest_index;
  logic [31:0] dest_value;
  logic [31:0] call_number;
  logic [31:0] call_arg0;
  logic [31:0] call_arg1;
  modport source (output valid, status, next_pc, dest_index, dest_value, call_number,
                  call_arg0, call_arg1, input ready);
  modport sink (input valid, status, next_pc, dest_index, dest_value, call_number,
                call_arg0, call_arg1, output ready);
endinterface

// ----- rtl/core/rv32i_instruction_executor_top.sv -----
// ----------------------------------------------------------------------------
// rv32i_instruction_executor_top
// RV32I execute block: pc, register file and byte data memory in memories.
// ----------------------------------------------------------------------------
// Each transaction runs in two stages: stage 1 reads rs1/rs2 from the register
// memory and the four bytes of a load from four byte-bank memories (bank =
// address low two bits), stage 2 computes, writes back and registers the
// result. A new transaction is taken only while stage 2 is empty, so the next
// one always sees the state written by the one before it. After reset a
// clearing pass zeroes the data memory and the register file before the first
// transaction is accepted. Results leave through an output register; while a
// result waits there, one more transaction is taken into stage 2 and held.
// ----------------------------------------------------------------------------
module rv32i_instruction_executor_top
  import rv32x_pkg::*;
#(
  parameter int MEM_ADDR_BITS = MemAddrBitsDefault
)(
  input logic clk,
  input logic rst_n,
  rv32x_in_if.sink in_ch,
  rv32x_out_if.source out_ch
);
  localparam int RowBits = MEM_ADDR_BITS - 2;
  localparam int Rows = 1 << RowBits;

  // memories: register file and four byte lanes
  logic [31:0] rf_mem [32];
  logic [7:0] dm_mem [4][Rows];

  // clearing pass
  logic clr_r;
  logic [RowBits:0] clr_cnt_r;

  // stage 2 (execute) registers
  logic s2_v_r;
  logic [1:0] s2_op_r;
  logic [31:0] s2_ins_r, s2_wv_r;
  logic [11:0] s2_ba_r;
  logic [4:0] s2_tr_r;
  logic [31:0] rs1_q, rs2_q, a7_q, a0_q, a1_q;
  logic [7:0] dq [4];
  logic [31:0] pc_r;

  // output register
  logic o_v_r;

  // hazard: stage 2 writes state, stage 1 must read it after
  logic s2_writes, out_free, stall, accept;
  assign s2_writes = s2_v_r;
  assign out_free = !o_v_r || out_ch.ready;
  assign stall = s2_v_r && (!out_free || s2_writes);
  assign in_ch.ready = !clr_r && !stall;
  assign accept = in_ch.valid && in_ch.ready;

  // ---- stage 1: address and reads ----
  logic [31:0] ld_addr;
  logic [31:0] in_immi;
  assign in_immi = {{20{in_ch.instruction[31]}}, in_ch.instruction[31:20]};
  assign ld_addr = rf_mem[in_ch.instruction[19:15]] + in_immi;

  logic [MEM_ADDR_BITS-1:0] ld_base;
  assign ld_base = ld_addr[MEM_ADDR_BITS-1:0];

  // read only on acceptance; hold the operands while stage 2 works
  always_ff @(posedge clk) begin
    if (accept) begin
      rs1_q <= rf_mem[in_ch.instruction[19:15]];
      rs2_q <= rf_mem[in_ch.instruction[24:20]];
      a7_q <= rf_mem[17];
      a0_q <= rf_mem[10];
      a1_q <= rf_mem[11];
      for (int k = 0; k < 4; k++) begin
        logic [MEM_ADDR_BITS-1:0] ba;
        ba = ld_base + MEM_ADDR_BITS'(k);
        dq[ba[1:0]] <= dm_mem[ba[1:0]][ba[MEM_ADDR_BITS-1:2]];
      end
    end
  end

  logic fire;
  assign fire = s2_v_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (accept) begin
      s2_v_r <= 1'b1;
    end else if (fire) begin
      s2_v_r <= 1'b0;
    end
    if (accept) begin
      s2_op_r <= in_ch.operation;
      s2_ins_r <= in_ch.instruction;
      s2_wv_r <= in_ch.write_value;
      s2_ba_r <= in_ch.byte_address;
      s2_tr_r <= in_ch.target_register;
    end
  end

  // ---- stage 2: execute ----
  logic [6:0] opc, f7;
  logic [2:0] f3;
  logic [4:0] rd;
  logic [31:0] immi, imms, immb, immj, immu, ea;
  logic [31:0] alu_b, alu_res, ldw, ldv, pc4;
  logic alu_alt, take;
  assign opc = s2_ins_r[6:0];
  assign f3 = s2_ins_r[14:12];
  assign f7 = s2_ins_r[31:25];
  assign rd = s2_ins_r[11:7];
  assign immi = {{20{s2_ins_r[31]}}, s2_ins_r[31:20]};
  assign imms = {{20{s2_ins_r[31]}}, s2_ins_r[31:25], s2_ins_r[11:7]};
  assign immb = {{20{s2_ins_r[31]}}, s2_ins_r[7], s2_ins_r[30:25], s2_ins_r[11:8], 1'b0};
  assign immj = {{12{s2_ins_r[31]}}, s2_ins_r[19:12], s2_ins_r[20], s2_ins_r[30:21], 1'b0};
  assign immu = s2_ins_r & UPPER_MASK;
  assign pc4 = pc_r + 32'd4;
  assign ea = rs1_q + ((opc == OPC_STORE) ? imms : immi);

  logic [MEM_ADDR_BITS-1:0] eb;
  assign eb = ea[MEM_ADDR_BITS-1:0];
  logic [1:0] l0, l1, l2, l3;
  assign l0 = eb[1:0];
  assign l1 = l0 + 2'd1;
  assign l2 = l0 + 2'd2;
  assign l3 = l0 + 2'd3;
  assign ldw = {dq[l3], dq[l2], dq[l1], dq[l0]};

  assign alu_b = (opc == OPC_OP) ? rs2_q : immi;
  // sub only for register ops; arithmetic shift right for both forms
  assign alu_alt = (f7 == F7_ALT) && ((f3 == 3'd5) || (opc == OPC_OP && f3 == 3'd0));

  rv32x_alu u_alu (
    .a(rs1_q), .b((opc == OPC_BRANCH) ? rs2_q : alu_b), .f3(f3), .alt(alu_alt),
    .res(alu_res), .take(take)
  );

  logic [1:0] st_nxt;
  logic [31:0] npc_nxt, rdv_nxt;
  logic wr_nxt, bad;
  logic [4:0] rdi_nxt;
  logic [2:0] st_n;  // bytes to store
  logic [31:0] c7_nxt, c0_nxt, c1_nxt;

  always_comb begin
    bad = 1'b0;
    wr_nxt = 1'b0;
    rdv_nxt = 32'd0;
    rdi_nxt = 5'd0;
    st_nxt = ST_OK;
    npc_nxt = pc_r;
    st_n = 3'd0;
    c7_nxt = 32'd0;
    c0_nxt = 32'd0;
    c1_nxt = 32'd0;
    ldv = 32'd0;
    case (f3)
      3'd0: ldv = {{24{ldw[7]}}, ldw[7:0]};
      3'd1: ldv = {{16{ldw[15]}}, ldw[15:0]};
      3'd2: ldv = ldw;
      3'd4: ldv = {24'd0, ldw[7:0]};
      3'd5: ldv = {16'd0, ldw[15:0]};
      default: ldv = 32'd0;
    endcase
    case (s2_op_r)
      OP_SETREG: begin
        wr_nxt = 1'b1;
        rdi_nxt = s2_tr_r;
        rdv_nxt = s2_wv_r;
      end
      OP_EXEC: begin
        npc_nxt = pc4;
        rdi_nxt = rd;
        case (opc)
          OPC_LOAD: begin
            wr_nxt = 1'b1;
            rdv_nxt = ldv;
            bad = (f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7);
          end
          OPC_OPIMM: begin
            wr_nxt = 1'b1;
            rdv_nxt = alu_res;
            bad = (f3 == 3'd1 && f7 != 7'd0) ||
                  (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT);
          end
          OPC_OP: begin
            wr_nxt = 1'b1;
            rdv_nxt = alu_res;
            bad = ((f3 == 3'd0 || f3 == 3'd5) && f7 != 7'd0 && f7 != F7_ALT) ||
                  (f3 != 3'd0 && f3 != 3'd5 && f7 != 7'd0 && 1'b0);
          end
          OPC_AUIPC: begin
            wr_nxt = 1'b1;
            rdv_nxt = pc_r + immu;
          end
          OPC_LUI: begin
            wr_nxt = 1'b1;
            rdv_nxt = immu;
          end
          OPC_STORE: begin
            if (f3 == 3'd0) st_n = 3'd1;
            else if (f3 == 3'd1) st_n = 3'd2;
            else if (f3 == 3'd2) st_n = 3'd4;
            else bad = 1'b1;
          end
          OPC_BRANCH: begin
            bad = (f3 == 3'd2) || (f3 == 3'd3);
            if (take) npc_nxt = pc_r + immb;
          end
          OPC_JALR: begin
            if (f3 == 3'd0) begin
              wr_nxt = 1'b1;
              rdv_nxt = pc4;
              npc_nxt = (rs1_q + immi) & ~32'd1;
            end else begin
              bad = 1'b1;
            end
          end
          OPC_JAL: begin
            wr_nxt = 1'b1;
            rdv_nxt = pc4;
            npc_nxt = pc_r + immj;
          end
          OPC_SYSTEM: begin
            if (f3 != 3'd0 || immi > 32'd1) begin
              bad = 1'b1;
            end else if (immi == 32'd0) begin
              st_nxt = ST_ECALL;
              c7_nxt = a7_q;
              c0_nxt = a0_q;
              c1_nxt = a1_q;
            end else begin
              st_nxt = ST_BREAK;
              npc_nxt = pc_r;
            end
          end
          default: bad = 1'b1;
        endcase
        if (bad) begin
          st_nxt = ST_ILLEGAL;
          npc_nxt = pc_r;
          wr_nxt = 1'b0;
          st_n = 3'd0;
        end
      end
      default: ;
    endcase
    if (!wr_nxt || rdi_nxt == 5'd0) begin
      rdi_nxt = 5'd0;
      rdv_nxt = 32'd0;
    end
  end

  // preload address wraps to the memory size
  logic [MEM_ADDR_BITS-1:0] pa;
  assign pa = MEM_ADDR_BITS'(s2_ba_r);

  // write-back and clearing pass
  always_ff @(posedge clk) begin
    if (clr_r) begin
      for (int k = 0; k < 4; k++) dm_mem[k][clr_cnt_r[RowBits-1:0]] <= 8'd0;
      rf_mem[clr_cnt_r[4:0]] <= 32'd0;
    end else if (fire) begin
      if (rdi_nxt != 5'd0) rf_mem[rdi_nxt] <= rdv_nxt;
      if (s2_op_r == OP_PRELOAD) begin
        dm_mem[pa[1:0]][pa[MEM_ADDR_BITS-1:2]] <= s2_wv_r[7:0];
      end
      for (int k = 0; k < 4; k++) begin
        logic [MEM_ADDR_BITS-1:0] wa;
        wa = eb + MEM_ADDR_BITS'(k);
        if (3'(k) < st_n) dm_mem[wa[1:0]][wa[MEM_ADDR_BITS-1:2]] <= rs2_q[8*k +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
      pc_r <= 32'd0;
      o_v_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        // cover at least the 32 register entries
        if (clr_cnt_r >= (RowBits + 1)'(Rows - 1) && clr_cnt_r >= (RowBits + 1)'(31))
          clr_r <= 1'b0;
      end
      if (fire && s2_op_r == OP_EXEC) pc_r <= npc_nxt;
      if (fire) o_v_r <= 1'b1;
      else if (out_ch.ready) o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.status <= st_nxt;
      out_ch.next_pc <= (s2_op_r == OP_EXEC) ? npc_nxt : pc_r;
      out_ch.dest_index <= rdi_nxt;
      out_ch.dest_value <= rdv_nxt;
      out_ch.call_number <= c7_nxt;
      out_ch.call_arg0 <= c0_nxt;
      out_ch.call_arg1 <= c1_nxt;
    end
  end
  assign out_ch.valid = o_v_r;

endmodule

// ----- rtl/core/rv32x_alu.sv -----
// ----------------------------------------------------------------------------
// rv32x_alu
// Combinational integer ALU and branch compare for one decoded instruction.
// ----------------------------------------------------------------------------
module rv32x_alu
  import rv32x_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [2:0]  f3,
  input  logic        alt,
  output logic [31:0] res,
  output logic        take
);
  logic [4:0] sh;
  logic lts, ltu;
  assign sh = b[4:0];
  assign lts = $signed(a) < $signed(b);
  assign ltu = a < b;

  always_comb begin
    case (f3)
      3'd0: res = alt ? (a - b) : (a + b);
      3'd1: res = a << sh;
      3'd2: res = {31'd0, lts};
      3'd3: res = {31'd0, ltu};
      3'd4: res = a ^ b;
      3'd5: res = alt ? 32'($signed(a) >>> sh) : (a >> sh);
      3'd6: res = a | b;
      default: res = a & b;
    endcase
    case (f3)
      3'd0: take = (a == b);
      3'd1: take = (a != b);
      3'd4: take = lts;
      3'd5: take = !lts;
      3'd6: take = ltu;
      3'd7: take = !ltu;
      default: take = 1'b0;
    endcase
  end
endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rv32i_instruction_executor_top. A local model of the
// pc, register file and byte memory predicts every result. Directed tests
// cover each instruction class and the corner cases, then random programs
// follow. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import rv32x_pkg::*;

  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    status_t     status;
    logic [31:0] next_pc;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] call_number;
    logic [31:0] call_arg0;
    logic [31:0] call_arg1;
  } result_t;

  logic clk;
  logic rst_n;

  rv32x_in_if  in_ch ();
  rv32x_out_if out_ch ();

  rv32i_instruction_executor_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Architectural copy of the block's state
  logic [31:0] model_pc;
  logic [31:0] model_regs [32];
  logic [7:0]  model_mem [4096];

  result_t pending_results [$];
  int      mismatches;
  int      sent_count;
  int      checked_count;
  int      idle_count;
  bit      steady;           // high while neither side may idle
  bit      stim_active;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Instruction encoders
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [4:0] rd, logic [2:0] f3,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [12:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  // ---------------------------------------------------------------------------
  // Execute one transaction against the local state and return its result
  // ---------------------------------------------------------------------------
  function automatic result_t execute_model(op_t op, logic [31:0] ins, logic [11:0] baddr,
                                            logic [31:0] wval, logic [4:0] treg);
    result_t     r;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, immi, immb, immj, immsv, ad, v;
    logic [4:0]  sh;
    bit          wr, bad, take;
    r = '0;
    r.status = ST_OK;
    r.next_pc = model_pc;
    wr = 0;
    bad = 0;
    take = 0;
    if (op == OP_PRELOAD) begin
      model_mem[baddr] = wval[7:0];
    end else if (op == OP_SETREG) begin
      r.dest_index = treg;
      r.dest_value = wval;
      wr = 1;
    end else if (op == OP_EXEC) begin
      opc = ins[6:0];
      f3 = ins[14:12];
      f7 = ins[31:25];
      a = model_regs[ins[19:15]];
      b = model_regs[ins[24:20]];
      immi = {{20{ins[31]}}, ins[31:20]};
      r.next_pc = model_pc + 32'd4;
      case (opc)
        OPC_LOAD: begin
          ad = a + immi;
          v = 0;
          for (int i = 0; i < 4; i++) v[8*i +: 8] = model_mem[12'(ad + i)];
          wr = 1;
          case (f3)
            3'd0: r.dest_value = {{24{v[7]}}, v[7:0]};
            3'd1: r.dest_value = {{16{v[15]}}, v[15:0]};
            3'd2: r.dest_value = v;
            3'd4: r.dest_value = {24'd0, v[7:0]};
            3'd5: r.dest_value = {16'd0, v[15:0]};
            default: bad = 1;
          endcase
        end
        OPC_OPIMM: begin
          sh = immi[4:0];
          wr = 1;
          case (f3)
            3'd0: r.dest_value = a + immi;
            3'd1: if (f7 == 0) r.dest_value = a << sh; else bad = 1;
            3'd2: r.dest_value = ($signed(a) < $signed(immi)) ? 32'd1 : 32'd0;
            3'd3: r.dest_value = (a < immi) ? 32'd1 : 32'd0;
            3'd4: r.dest_value = a ^ immi;
            3'd5: begin
              if (f7 == 0) r.dest_value = a >> sh;
              else if (f7 == F7_ALT) r.dest_value = $signed(a) >>> sh;
              else bad = 1;
            end
            3'd6: r.dest_value = a | immi;
            default: r.dest_value = a & immi;
          endcase
        end
        OPC_AUIPC: begin
          wr = 1;
          r.dest_value = model_pc + (ins & UPPER_MASK);
        end
        OPC_LUI: begin
          wr = 1;
          r.dest_value = ins & UPPER_MASK;
        end
        OPC_STORE: begin
          immsv = {{20{ins[31]}}, ins[31:25], ins[11:7]};
          ad = a + immsv;
          if (f3 <= 3'd2) begin
            for (int i = 0; i < (1 << f3); i++) model_mem[12'(ad + i)] = b[8*i +: 8];
          end else begin
            bad = 1;
          end
        end
        OPC_OP: begin
          sh = b[4:0];
          wr = 1;
          case (f3)
            3'd0: begin
              if (f7 == 0) r.dest_value = a + b;
              else if (f7 == F7_ALT) r.dest_value = a - b;
              else bad = 1;
            end
            3'd1: r.dest_value = a << sh;
            3'd2: r.dest_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            3'd3: r.dest_value = (a < b) ? 32'd1 : 32'd0;
            3'd4: r.dest_value = a ^ b;
            3'd5: begin
              if (f7 == 0) r.dest_value = a >> sh;
              else if (f7 == F7_ALT) r.dest_value = $signed(a) >>> sh;
              else bad = 1;
            end
            3'd6: r.dest_value = a | b;
            default: r.dest_value = a & b;
          endcase
        end
        OPC_BRANCH: begin
          immb = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
          case (f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: bad = 1;
          endcase
          if (take) r.next_pc = model_pc + immb;
        end
        OPC_JALR: begin
          if (f3 == 0) begin
            wr = 1;
            r.dest_value = model_pc + 32'd4;
            r.next_pc = (a + immi) & ~32'd1;
          end else begin
            bad = 1;
          end
        end
        OPC_JAL: begin
          immj = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
          wr = 1;
          r.dest_value = model_pc + 32'd4;
          r.next_pc = model_pc + immj;
        end
        OPC_SYSTEM: begin
          if (f3 != 0 || immi > 32'd1) begin
            bad = 1;
          end else if (immi == 0) begin
            r.status = ST_ECALL;
            r.call_number = model_regs[17];
            r.call_arg0 = model_regs[10];
            r.call_arg1 = model_regs[11];
          end else begin
            r.status = ST_BREAK;
            r.next_pc = model_pc;
          end
        end
        default: bad = 1;
      endcase
      if (bad) begin
        r.status = ST_ILLEGAL;
        r.next_pc = model_pc;
        wr = 0;
      end
      if (wr) r.dest_index = ins[11:7];
      model_pc = r.next_pc;
    end
    if (!wr || r.dest_index == 0) begin
      r.dest_index = 0;
      r.dest_value = 0;
    end else begin
      model_regs[r.dest_index] = r.dest_value;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Send one transaction; predict its result once it is accepted
  // ---------------------------------------------------------------------------
  task automatic send_item(op_t op, logic [31:0] ins = '0, logic [11:0] baddr = '0,
                           logic [31:0] wval = '0, logic [4:0] treg = '0);
    while (!steady && $urandom_range(0, 99) < 18) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.instruction = ins;
    in_ch.byte_address = baddr;
    in_ch.write_value = wval;
    in_ch.target_register = treg;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(execute_model(op, ins, baddr, wval, treg));
    sent_count++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [2:0]  f3;
    w = $urandom();
    case ($urandom_range(0, 11))
      0: begin
        f3 = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        w = {w[31:15], f3, w[11:7], OPC_LOAD};
      end
      1: begin
        w[31:25] = ($urandom_range(0, 9) == 0) ? w[31:25] : ($urandom_range(0, 1) ? F7_ALT : 7'd0);
        w[6:0] = OPC_OPIMM;
      end
      2: w[6:0] = OPC_AUIPC;
      3: w[6:0] = OPC_LUI;
      4: begin
        f3 = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(0, 2));
        w = {w[31:15], f3, w[11:7], OPC_STORE};
      end
      5, 6: begin
        w[31:25] = ($urandom_range(0, 9) == 0) ? w[31:25] : ($urandom_range(0, 1) ? F7_ALT : 7'd0);
        w[6:0] = OPC_OP;
      end
      7: w[6:0] = OPC_BRANCH;
      8: begin
        if ($urandom_range(0, 7) != 0) w[14:12] = 3'd0;
        w[6:0] = OPC_JALR;
      end
      9: w[6:0] = OPC_JAL;
      10: begin
        if ($urandom_range(0, 4) != 0) w = enc_i(OPC_SYSTEM, w[11:7], 3'd0, w[19:15],
                                                 12'($urandom_range(0, 1)));
        else w[6:0] = OPC_SYSTEM;
      end
      default: ;
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order comparison
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = rst_n && (steady || $urandom_range(0, 99) >= 18);
    end
  end

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %h, got %h", name, expv, actv);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", 32'(e.status), 32'(out_ch.status));
        check_field("next_pc", e.next_pc, out_ch.next_pc);
        check_field("dest_index", 32'(e.dest_index), 32'(out_ch.dest_index));
        check_field("dest_value", e.dest_value, out_ch.dest_value);
        check_field("call_number", e.call_number, out_ch.call_number);
        check_field("call_arg0", e.call_arg0, out_ch.call_arg0);
        check_field("call_arg1", e.call_arg1, out_ch.call_arg1);
        checked_count++;
      end
    end
  end

  // Watchdog: covers the clearing pass after reset and any hang
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !stim_active) begin
      idle_count <= 0;
    end else if (idle_count >= WatchdogLimit) begin
      $display("rv32i_instruction_executor_top: mismatch");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_side_ops();
    send_item(OP_SETREG, .wval(32'hFFFF_FFFF), .treg(5'd0));    // x0 stays zero
    send_item(OP_SETREG, .wval(32'h8000_0000), .treg(5'd1));
    send_item(OP_SETREG, .wval(32'hFFFF_FFFF), .treg(5'd31));
    send_item(OP_PRELOAD, .baddr(12'hFFF), .wval(32'hA5A5_A581));
    send_item(OP_PRELOAD, .baddr(12'h000), .wval(32'h0000_007F));
    send_item(OP_NONE, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 5'd31);
  endtask

  task automatic test_memory();
    // word load straddling the top of memory wraps to address 0
    send_item(OP_EXEC, enc_i(OPC_LOAD, 5'd2, 3'd2, 5'd0, 12'hFFE));
    send_item(OP_EXEC, enc_i(OPC_LOAD, 5'd3, 3'd0, 5'd0, 12'hFFF));  // lb, negative
    send_item(OP_EXEC, enc_i(OPC_LOAD, 5'd4, 3'd5, 5'd0, 12'hFFF));  // lhu wrap
    send_item(OP_EXEC, enc_s(3'd2, 5'd1, 5'd31, 12'h003));           // misaligned sw
    send_item(OP_EXEC, enc_i(OPC_LOAD, 5'd5, 3'd1, 5'd0, 12'h002));
  endtask

  task automatic test_alu();
    send_item(OP_EXEC, enc_i(OPC_OPIMM, 5'd6, 3'd5, 5'd1, {F7_ALT, 5'd31}));  // srai
    send_item(OP_EXEC, enc_r(F7_ALT, 5'd31, 5'd1, 3'd0, 5'd7));               // sub
    send_item(OP_EXEC, enc_r(7'd0, 5'd31, 5'd1, 3'd2, 5'd8));                 // slt
    send_item(OP_EXEC, enc_r(7'd0, 5'd31, 5'd1, 3'd3, 5'd9));                 // sltu
    send_item(OP_EXEC, {20'hFFFFF, 5'd10, OPC_LUI});
    send_item(OP_EXEC, {20'h80000, 5'd11, OPC_AUIPC});
  endtask

  task automatic test_control();
    send_item(OP_EXEC, enc_b(3'd4, 5'd0, 5'd1, 13'h1FFE));           // blt taken backward
    send_item(OP_EXEC, enc_j(5'd1, 21'h0_0006));                     // jal, offset not a multiple of four
    send_item(OP_EXEC, enc_i(OPC_JALR, 5'd5, 3'd0, 5'd5, 12'hFFF));  // rd == rs1
    send_item(OP_EXEC, enc_i(OPC_JALR, 5'd5, 3'd1, 5'd5, 12'h000));  // illegal jalr
  endtask

  task automatic test_system_and_illegal();
    send_item(OP_SETREG, .wval(32'd93), .treg(5'd17));
    send_item(OP_EXEC, enc_i(OPC_SYSTEM, 5'd0, 3'd0, 5'd0, 12'd0));   // ecall
    send_item(OP_EXEC, enc_i(OPC_SYSTEM, 5'd0, 3'd0, 5'd0, 12'd1));   // ebreak
    send_item(OP_EXEC, enc_i(OPC_OPIMM, 5'd3, 3'd1, 5'd1, 12'h401)); // slli, bad funct7
    send_item(OP_EXEC, 32'hFFFF_FFFF);                                 // unknown opcode
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      steady = (n >= count / 3) && (n < count / 3 + 150);
      case ($urandom_range(0, 19))
        0, 1, 2: send_item(OP_SETREG, .wval($urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 64))
                                             : $urandom()), .treg(5'($urandom())));
        3, 4: send_item(OP_PRELOAD, .baddr(12'($urandom())), .wval($urandom()));
        5: send_item(OP_NONE, $urandom(), 12'($urandom()), $urandom(), 5'($urandom()));
        default: send_item(OP_EXEC, rand_instr(), 12'($urandom()), $urandom(), 5'($urandom()));
      endcase
    end
    steady = 0;
  endtask

  initial begin
    model_pc = 0;
    foreach (model_regs[i]) model_regs[i] = 0;
    foreach (model_mem[i]) model_mem[i] = 0;
    mismatches = 0;
    sent_count = 0;
    checked_count = 0;
    idle_count = 0;
    steady = 0;
    stim_active = 0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_NONE;
    in_ch.instruction = '0;
    in_ch.byte_address = '0;
    in_ch.write_value = '0;
    in_ch.target_register = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    stim_active = 1;

    test_side_ops();
    test_memory();
    test_alu();
    test_control();
    test_system_and_illegal();
    test_random(1000);

    // drain outstanding results, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    stim_active = 0;
    repeat (20) @(posedge clk);

    $display("Ran %0d transactions (side ops, loads/stores with wrap, ALU, branches, jumps,",
             sent_count);
    $display("system and illegal encodings); %0d results compared.", checked_count);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("rv32i_instruction_executor_top: match");
    end else begin
      $display("rv32i_instruction_executor_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rv32x_pkg.sv
rtl/core/rv32x_if.sv
rtl/core/rv32x_alu.sv
rtl/core/rv32i_instruction_executor_top.sv
tb/testbench.sv
